### hw/rtl/ultrasonic_echo_ranger_macros.svh
// Assertion macros for the ultrasonic echo ranger.
// Included by the top level; expects a clock named clk and reset arst_n.
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define UER_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ultrasonic_echo_ranger: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define UER_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ultrasonic_echo_ranger: next-cycle check failed");

`endif

### hw/rtl/uer_pkg.sv
// Shared types and codes for the ultrasonic echo ranger.
// No dependencies; used by uer_calc and ultrasonic_echo_ranger.
package uer_pkg;

	// Report kinds
	localparam logic [1:0] KIND_TRIGGER = 2'd0;
	localparam logic [1:0] KIND_MEASURE = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT = 2'd2;

	// Configuration register indexes
	localparam logic CFG_TIMEOUT = 1'b0;
	localparam logic CFG_SCALE   = 1'b1;

	// Field widths fixed by the interface
	localparam int NOW_W   = 32;
	localparam int FIELD_W = 24;
	localparam int TMO_W   = 20;
	localparam int SCALE_W = 16;

	localparam logic [TMO_W-1:0]   TIMEOUT_RST = 20'd30000;
	localparam logic [SCALE_W-1:0] SCALE_RST   = 16'd1124;

	// Measurement flags
	typedef struct packed {
		logic measuring;
		logic have_sample;
	} flags_t;

	// One result item
	typedef struct packed {
		logic [1:0]         kind;
		logic [FIELD_W-1:0] width;
		logic [FIELD_W-1:0] distance;
		logic               valid;
	} result_t;

endpackage

### hw/rtl/uer_calc.sv
// Next-state and result logic for one event of the echo ranger.
// Depends on uer_pkg; instantiated by ultrasonic_echo_ranger.
module uer_calc #(
	parameter int TIME_BITS  = 32,
	parameter int WIDTH_BITS = 24
) (
	input  logic                        action,
	input  logic                        level,
	input  logic [TIME_BITS-1:0]        now,
	input  logic [TIME_BITS-1:0]        echo_start,
	input  logic [TIME_BITS-1:0]        echo_end,
	input  logic [TIME_BITS-1:0]        trig_stamp,
	input  uer_pkg::flags_t             flags,
	input  logic [uer_pkg::TMO_W-1:0]   timeout_us,
	input  logic [uer_pkg::SCALE_W-1:0] scale_q16,
	output logic [TIME_BITS-1:0]        nxt_start,
	output logic [TIME_BITS-1:0]        nxt_end,
	output logic [TIME_BITS-1:0]        nxt_trig,
	output uer_pkg::flags_t             nxt_flags,
	output logic                        has_result,
	output uer_pkg::result_t            result
);

	localparam logic [63:0] WIDTH_MAX = (WIDTH_BITS < uer_pkg::FIELD_W) ?
		((64'd1 << WIDTH_BITS) - 64'd1) : ((64'd1 << uer_pkg::FIELD_W) - 64'd1);
	localparam int PROD_W = uer_pkg::NOW_W + uer_pkg::SCALE_W;

	logic [TIME_BITS-1:0]           dw;
	logic [TIME_BITS-1:0]           de;
	logic                           w_pos;
	logic                           e_pos;
	logic [63:0]                    w_ext;
	logic [63:0]                    e_ext;
	logic                           w_high;
	logic [PROD_W-1:0]              prod;
	logic [PROD_W-9:0]              dist_full;
	logic                           dist_sat;
	logic [uer_pkg::FIELD_W-1:0]    width_out;
	logic [uer_pkg::FIELD_W-1:0]    dist_out;
	logic                           timed_out;

	// Echo width and time since trigger, as signed differences
	assign dw    = echo_end - echo_start;
	assign de    = now - trig_stamp;
	assign w_pos = (dw != '0) && !dw[TIME_BITS-1];
	assign e_pos = (de != '0) && !de[TIME_BITS-1];
	assign w_ext = 64'(dw);
	assign e_ext = 64'(de);

	// Scale the width; anything at or above 2^32 saturates unless the scale is zero
	assign w_high    = |w_ext[63:uer_pkg::NOW_W];
	assign prod      = PROD_W'(w_ext[uer_pkg::NOW_W-1:0]) * PROD_W'(scale_q16);
	assign dist_full = prod[PROD_W-1:8];
	assign dist_sat  = (w_high && (scale_q16 != '0)) || (|dist_full[PROD_W-9:uer_pkg::FIELD_W]);
	assign dist_out  = dist_sat ? '1 : dist_full[uer_pkg::FIELD_W-1:0];
	assign width_out = (w_ext > WIDTH_MAX) ? WIDTH_MAX[uer_pkg::FIELD_W-1:0]
		: w_ext[uer_pkg::FIELD_W-1:0];

	assign timed_out = e_pos && (e_ext > 64'(timeout_us));

	// Decide the event
	always_comb begin
		nxt_start  = echo_start;
		nxt_end    = echo_end;
		nxt_trig   = trig_stamp;
		nxt_flags  = flags;
		has_result = 1'b0;
		result     = '0;
		if (!action) begin
			if (level) begin
				nxt_start = now;
				nxt_flags = '{measuring: 1'b1, have_sample: 1'b0};
			end else begin
				nxt_end   = now;
				nxt_flags = '{measuring: 1'b0, have_sample: 1'b1};
			end
		end else begin
			priority if (!flags.measuring && !flags.have_sample) begin
				nxt_start   = '0;
				nxt_end     = '0;
				nxt_trig    = now;
				nxt_flags   = '{measuring: 1'b1, have_sample: 1'b0};
				has_result  = 1'b1;
				result.kind = uer_pkg::KIND_TRIGGER;
			end else if (flags.have_sample) begin
				nxt_flags   = '0;
				has_result  = 1'b1;
				result.kind = uer_pkg::KIND_MEASURE;
				if (w_pos) begin
					result.width    = width_out;
					result.distance = dist_out;
					result.valid    = 1'b1;
				end
			end else if (timed_out) begin
				nxt_flags   = '0;
				has_result  = 1'b1;
				result.kind = uer_pkg::KIND_TIMEOUT;
			end else begin
				// still waiting: hold the state, no report
				has_result = 1'b0;
			end
		end
	end

endmodule

### hw/rtl/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: event register, state, result register.
// Depends on uer_pkg, uer_calc and ultrasonic_echo_ranger_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one event: action 0 is an echo
//   pin edge (echo_level gives the new level), action 1 is a poll; now_us is
//   the microsecond timestamp of the event.
//   Output channel (out_valid/out_ready) carries at most one report per event:
//   trigger command, measurement (width and distance) or timeout.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes timeout_us
//   (index 0) and scale_q16 (index 1); cfg_ready is always high.
//   The event register loads at the event transfer and the result register
//   loads from it when the event stage advances, which a full result
//   register can hold off. Throughput: one event per cycle while no event's
//   report finds the result register full; uer_calc is combinational.
//   When the receiver stalls, the result register holds its report; events
//   that give no report keep flowing, and an event that gives one waits in the
//   event register, which drops in_ready until the result register frees.
//   Reset clears all timestamps and flags, empties both registers and loads
//   timeout 30000 us and scale 1124 (0.01715 cm/us in Q0.16).
`include "ultrasonic_echo_ranger_macros.svh"

module ultrasonic_echo_ranger #(
	parameter int TIME_BITS  = 32,
	parameter int WIDTH_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic                          echo_level,
	input  logic [uer_pkg::NOW_W-1:0]     now_us,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    report_kind,
	output logic [uer_pkg::FIELD_W-1:0]   echo_width,
	output logic [uer_pkg::FIELD_W-1:0]   distance_q8,
	output logic                          distance_valid,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [uer_pkg::TMO_W-1:0]     cfg_data
);

	logic                          valid_s1;
	logic                          action_s1;
	logic                          level_s1;
	logic [TIME_BITS-1:0]          now_s1;

	logic [TIME_BITS-1:0]          start_q;
	logic [TIME_BITS-1:0]          end_q;
	logic [TIME_BITS-1:0]          trig_q;
	uer_pkg::flags_t               flags_q;
	logic [uer_pkg::TMO_W-1:0]     timeout_q;
	logic [uer_pkg::SCALE_W-1:0]   scale_q;

	logic                          out_valid_q;
	uer_pkg::result_t              res_q;

	logic [TIME_BITS-1:0]          nxt_start;
	logic [TIME_BITS-1:0]          nxt_end;
	logic [TIME_BITS-1:0]          nxt_trig;
	uer_pkg::flags_t               nxt_flags;
	logic                          has_result;
	uer_pkg::result_t              result;
	logic                          s1_go;

	// Event stage advances unless its report finds the result register full
	assign s1_go     = valid_s1 && (!has_result || !out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || s1_go;
	assign cfg_ready = 1'b1;

	// Capture the event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			level_s1  <= echo_level;
			now_s1    <= TIME_BITS'(now_us);
		end
	end

	uer_calc #(
		.TIME_BITS  (TIME_BITS),
		.WIDTH_BITS (WIDTH_BITS)
	) u_calc (
		.action     (action_s1),
		.level      (level_s1),
		.now        (now_s1),
		.echo_start (start_q),
		.echo_end   (end_q),
		.trig_stamp (trig_q),
		.flags      (flags_q),
		.timeout_us (timeout_q),
		.scale_q16  (scale_q),
		.nxt_start  (nxt_start),
		.nxt_end    (nxt_end),
		.nxt_trig   (nxt_trig),
		.nxt_flags  (nxt_flags),
		.has_result (has_result),
		.result     (result)
	);

	// Update measurement state on each processed event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= '0;
			trig_q  <= '0;
			flags_q <= '0;
		end else if (s1_go) begin
			start_q <= nxt_start;
			end_q   <= nxt_end;
			trig_q  <= nxt_trig;
			flags_q <= nxt_flags;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= uer_pkg::TIMEOUT_RST;
			scale_q   <= uer_pkg::SCALE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				uer_pkg::CFG_TIMEOUT: timeout_q <= cfg_data;
				uer_pkg::CFG_SCALE:   scale_q   <= cfg_data[uer_pkg::SCALE_W-1:0];
			endcase
		end
	end

	// Result register: load a new report, drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && has_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && has_result) begin
			res_q <= result;
		end
	end

	assign out_valid      = out_valid_q;
	assign report_kind    = res_q.kind;
	assign echo_width     = res_q.width;
	assign distance_q8    = res_q.distance;
	assign distance_valid = res_q.valid;

	// Checks
	`UER_ASSERT_NOW(a_flags_excl, 1'b1, !(flags_q.measuring && flags_q.have_sample))
	`UER_ASSERT_NOW(a_non_measure_zero, out_valid_q && (res_q.kind != uer_pkg::KIND_MEASURE),
		(res_q.width == '0) && (res_q.distance == '0) && !res_q.valid)
	`UER_ASSERT_NOW(a_invalid_zero, out_valid_q && !res_q.valid,
		(res_q.width == '0) && (res_q.distance == '0))
	`UER_ASSERT_NEXT(a_report_loaded, s1_go && has_result, out_valid_q)

endmodule

### tb/sv/ultrasonic_echo_ranger_tb.sv
// Self-checking testbench for ultrasonic_echo_ranger: directed and random echo
// edge and poll traffic, each report checked against an in-bench ranging predictor.
// Depends on uer_pkg and the ultrasonic_echo_ranger RTL.
module ultrasonic_echo_ranger_tb;

	typedef enum logic {ACT_EDGE = 1'b0, ACT_POLL = 1'b1} action_t;
	typedef enum logic {ECHO_FALL = 1'b0, ECHO_RISE = 1'b1} level_t;

	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASE_EVENTS  = 220;
	localparam logic [uer_pkg::FIELD_W-1:0] FIELD_MAX = '1;
	localparam logic [uer_pkg::TMO_W-1:0]   TIMEOUT_MAX = '1;
	localparam logic [uer_pkg::TMO_W-1:0]   CFG_DATA_ALL = '1;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic                          action = 1'b0;
	logic                          echo_level = 1'b0;
	logic [uer_pkg::NOW_W-1:0]     now_us = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [1:0]                    report_kind;
	logic [uer_pkg::FIELD_W-1:0]   echo_width;
	logic [uer_pkg::FIELD_W-1:0]   distance_q8;
	logic                          distance_valid;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic                          cfg_index = uer_pkg::CFG_TIMEOUT;
	logic [uer_pkg::TMO_W-1:0]     cfg_data = '0;

	// Predictor copy of the ranging state and registers
	logic [uer_pkg::NOW_W-1:0]     rise_us;
	logic [uer_pkg::NOW_W-1:0]     fall_us;
	logic [uer_pkg::NOW_W-1:0]     trig_us;
	logic                          busy_flag;
	logic                          ready_flag;
	logic [uer_pkg::TMO_W-1:0]     limit_us;
	logic [uer_pkg::SCALE_W-1:0]   scale_frac;

	uer_pkg::result_t pending_reports[$];
	int faults = 0;
	int events_sent = 0;
	int idle_cycles = 0;
	int gap_pct = 20;
	bit calm = 1'b0;

	ultrasonic_echo_ranger dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.echo_level     (echo_level),
		.now_us         (now_us),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.report_kind    (report_kind),
		.echo_width     (echo_width),
		.distance_q8    (distance_q8),
		.distance_valid (distance_valid),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #10 clk = ~clk;

	// Advance the ranging state by one event; return 1 with the report it causes
	function automatic bit predict_report(input action_t act, input level_t lvl,
			input logic [uer_pkg::NOW_W-1:0] ts, output uer_pkg::result_t rep);
		logic [uer_pkg::NOW_W-1:0]                  span;
		logic [uer_pkg::NOW_W-1:0]                  elapsed;
		logic [uer_pkg::NOW_W+uer_pkg::SCALE_W-1:0] product;
		rep = '0;
		if (act == ACT_EDGE) begin
			if (lvl == ECHO_RISE) begin
				rise_us = ts;
				busy_flag = 1'b1;
				ready_flag = 1'b0;
			end else begin
				fall_us = ts;
				busy_flag = 1'b0;
				ready_flag = 1'b1;
			end
			return 1'b0;
		end
		// idle: start a new measurement
		if (!busy_flag && !ready_flag) begin
			rise_us = '0;
			fall_us = '0;
			trig_us = ts;
			busy_flag = 1'b1;
			rep.kind = uer_pkg::KIND_TRIGGER;
			return 1'b1;
		end
		// finished sample: width and distance, zero unless strictly positive
		if (ready_flag) begin
			span = fall_us - rise_us;
			rep.kind = uer_pkg::KIND_MEASURE;
			if (span != '0 && !span[uer_pkg::NOW_W-1]) begin
				product = span * scale_frac;
				rep.width = (span > FIELD_MAX) ? FIELD_MAX : span[uer_pkg::FIELD_W-1:0];
				rep.distance = (product[uer_pkg::NOW_W+uer_pkg::SCALE_W-1:8] > FIELD_MAX) ?
					FIELD_MAX : product[uer_pkg::FIELD_W+7:8];
				rep.valid = 1'b1;
			end
			busy_flag = 1'b0;
			ready_flag = 1'b0;
			return 1'b1;
		end
		// still waiting: time out only on a positive elapsed time past the limit
		elapsed = ts - trig_us;
		if (elapsed != '0 && !elapsed[uer_pkg::NOW_W-1] && elapsed > limit_us) begin
			busy_flag = 1'b0;
			ready_flag = 1'b0;
			rep.kind = uer_pkg::KIND_TIMEOUT;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void log_fault(input string msg);
		faults++;
		if (faults <= 10)
			$display("%s", msg);
	endfunction

	// Offer one event, hold it until the transfer, then predict its report
	task automatic send_event(input action_t act, input level_t lvl,
			input logic [uer_pkg::NOW_W-1:0] ts);
		uer_pkg::result_t rep;
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		echo_level <= lvl;
		now_us <= ts;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		events_sent++;
		if (predict_report(act, lvl, ts, rep))
			pending_reports.push_back(rep);
	endtask

	// Drop the event channel and let the block settle with nothing outstanding
	task automatic drain_block();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [uer_pkg::TMO_W-1:0] value);
		drain_block();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == uer_pkg::CFG_TIMEOUT)
			limit_us = value;
		else
			scale_frac = value[uer_pkg::SCALE_W-1:0];
	endtask

	// Reset registers: trigger, the limit boundary, a negative elapsed time
	task automatic test_power_up_defaults();
		send_event(ACT_POLL, ECHO_RISE, 32'd0);
		send_event(ACT_POLL, ECHO_FALL, 32'd30000);
		send_event(ACT_POLL, ECHO_FALL, 32'hFFFF_FFFF);
		send_event(ACT_POLL, ECHO_FALL, 32'd30001);
	endtask

	// Largest positive width, zero width and negative width
	task automatic test_echo_widths();
		send_event(ACT_POLL, ECHO_FALL, 32'hFFFF_FF00);
		send_event(ACT_EDGE, ECHO_FALL, 32'h7FFF_FFFF);
		send_event(ACT_POLL, ECHO_FALL, 32'h8000_0000);
		send_event(ACT_POLL, ECHO_FALL, 32'h0000_0100);
		send_event(ACT_EDGE, ECHO_RISE, 32'h0000_0200);
		send_event(ACT_EDGE, ECHO_FALL, 32'h0000_0200);
		send_event(ACT_POLL, ECHO_RISE, 32'h0000_0300);
		send_event(ACT_POLL, ECHO_FALL, 32'h0000_1000);
		send_event(ACT_EDGE, ECHO_RISE, 32'h0000_2000);
		send_event(ACT_EDGE, ECHO_FALL, 32'h0000_1800);
		send_event(ACT_POLL, ECHO_FALL, 32'h0000_2100);
	endtask

	// Edges while idle, and a rising edge that discards a ready sample
	task automatic test_edge_ordering();
		send_event(ACT_EDGE, ECHO_RISE, 32'd20);
		send_event(ACT_EDGE, ECHO_FALL, 32'd30);
		send_event(ACT_EDGE, ECHO_RISE, 32'd40);
		send_event(ACT_POLL, ECHO_FALL, 32'd50);
		send_event(ACT_EDGE, ECHO_FALL, 32'd5871);
		send_event(ACT_POLL, ECHO_FALL, 32'd6000);
	endtask

	// Zero limit and full scale, with unused data bits set on the scale write
	task automatic test_config_extremes();
		write_register(uer_pkg::CFG_TIMEOUT, '0);
		write_register(uer_pkg::CFG_SCALE, CFG_DATA_ALL);
		send_event(ACT_POLL, ECHO_FALL, 32'h1234_5678);
		send_event(ACT_POLL, ECHO_FALL, 32'h1234_5678);
		send_event(ACT_POLL, ECHO_FALL, 32'h1234_5679);
		send_event(ACT_POLL, ECHO_FALL, 32'hFFFF_FFF0);
		send_event(ACT_EDGE, ECHO_FALL, 32'h0010_0000);
		send_event(ACT_POLL, ECHO_FALL, 32'h0010_0040);
	endtask

	// Mostly complete ranging cycles and timeouts, some noise, over several settings
	task automatic test_random_ranging();
		logic [uer_pkg::NOW_W-1:0] t0;
		logic [uer_pkg::NOW_W-1:0] t_rise;
		logic [uer_pkg::NOW_W-1:0] span;
		int shape;
		int stop_at;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					write_register(uer_pkg::CFG_TIMEOUT,
						uer_pkg::TMO_W'($urandom_range(1000, 60000)));
					write_register(uer_pkg::CFG_SCALE,
						uer_pkg::TMO_W'($urandom_range(0, 65535)));
				end
				1: begin
					write_register(uer_pkg::CFG_TIMEOUT, '0);
					write_register(uer_pkg::CFG_SCALE, CFG_DATA_ALL);
				end
				2: begin
					write_register(uer_pkg::CFG_TIMEOUT, TIMEOUT_MAX);
					write_register(uer_pkg::CFG_SCALE, '0);
				end
				3: begin
					write_register(uer_pkg::CFG_TIMEOUT, uer_pkg::TMO_W'($urandom()));
					write_register(uer_pkg::CFG_SCALE, uer_pkg::TMO_W'($urandom()));
				end
				default: begin
					write_register(uer_pkg::CFG_TIMEOUT, uer_pkg::TIMEOUT_RST);
					write_register(uer_pkg::CFG_SCALE,
						{{(uer_pkg::TMO_W-uer_pkg::SCALE_W){1'b0}}, uer_pkg::SCALE_RST});
					calm = 1'b1;
				end
			endcase
			stop_at = events_sent + PHASE_EVENTS;
			while (events_sent < stop_at) begin
				gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
				shape = $urandom_range(0, 9);
				t0 = $urandom();
				if (shape <= 5) begin
					// trigger, echo pulse, poll for the sample
					case ($urandom_range(0, 9))
						0: span = '0;
						1: span = {1'b1, 31'($urandom())};
						2: span = $urandom();
						default: span = $urandom_range(1, 40000);
					endcase
					t_rise = t0 + $urandom_range(1, 500);
					send_event(ACT_POLL, level_t'($urandom_range(0, 1)), t0);
					send_event(ACT_EDGE, ECHO_RISE, t_rise);
					send_event(ACT_EDGE, ECHO_FALL, t_rise + span);
					send_event(ACT_POLL, level_t'($urandom_range(0, 1)),
						t_rise + span + $urandom_range(0, 100));
				end else if (shape <= 7) begin
					// trigger, a poll inside the window, then polls around the limit
					send_event(ACT_POLL, level_t'($urandom_range(0, 1)), t0);
					send_event(ACT_POLL, level_t'($urandom_range(0, 1)),
						t0 + $urandom_range(0, limit_us));
					repeat ($urandom_range(1, 3))
						send_event(ACT_POLL, level_t'($urandom_range(0, 1)),
							t0 + limit_us + $urandom_range(0, 4) - 2);
				end else begin
					// stray edges and polls at random times
					repeat ($urandom_range(1, 4))
						send_event(action_t'($urandom_range(0, 1)),
							level_t'($urandom_range(0, 1)), $urandom());
				end
			end
		end
	endtask

	// Pace the receiver with random stall bursts
	initial begin : pace_receiver
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Compare each report transfer with the oldest prediction
	always @(posedge clk) begin : check_reports
		uer_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				log_fault($sformatf("unexpected report: kind %0d width %0d dist %0d valid %0d",
					report_kind, echo_width, distance_q8, distance_valid));
			end else begin
				want = pending_reports.pop_front();
				if (report_kind !== want.kind || echo_width !== want.width ||
						distance_q8 !== want.distance || distance_valid !== want.valid)
					log_fault($sformatf({"report mismatch: expected kind %0d width %0d ",
						"dist %0d valid %0d, got kind %0d width %0d dist %0d valid %0d"},
						want.kind, want.width, want.distance, want.valid,
						report_kind, echo_width, distance_q8, distance_valid));
			end
		end
	end

	// Stop the run when no channel has moved for too long
	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : run_tests
		// assert reset after every process is waiting, so the falling edge is seen
		arst_n <= 1'b0;
		rise_us = '0;
		fall_us = '0;
		trig_us = '0;
		busy_flag = 1'b0;
		ready_flag = 1'b0;
		limit_us = uer_pkg::TIMEOUT_RST;
		scale_frac = uer_pkg::SCALE_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_power_up_defaults();
		test_echo_widths();
		test_edge_ordering();
		test_config_extremes();
		test_random_ranging();
		drain_block();
		repeat (8) @(posedge clk);
		if (faults == 0 && pending_reports.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/uer_pkg.sv
hw/rtl/uer_calc.sv
hw/rtl/ultrasonic_echo_ranger.sv
tb/sv/ultrasonic_echo_ranger_tb.sv
